### src/ibc_pkg.sv
// shared types, constants and helpers for the interval bound concretizer
// no dependencies; used by every module of the block by scoped names
package ibc_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic signed [63:0] BOUND_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] BOUND_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic signed [31:0] lower_coef;
    logic signed [31:0] upper_coef;
    logic signed [31:0] source_low;
    logic signed [31:0] source_high;
    logic signed [31:0] bias_lower;
    logic signed [31:0] bias_upper;
    logic signed [31:0] prior_low;
    logic signed [31:0] prior_high;
    logic               last_term;
  } ibc_req_t;

  typedef struct packed {
    logic signed [31:0] new_low;
    logic signed [31:0] new_high;
    logic               saturated;
  } ibc_rsp_t;

  // products after the fraction shift, with the final-term fields
  typedef struct packed {
    logic signed [63:0] prod_low;
    logic signed [63:0] prod_high;
    logic signed [31:0] bias_lower;
    logic signed [31:0] bias_upper;
    logic signed [31:0] prior_low;
    logic signed [31:0] prior_high;
    logic               last_term;
  } ibc_prod_t;

  // completed sums of one neuron
  typedef struct packed {
    logic signed [63:0] sum_low;
    logic signed [63:0] sum_high;
    logic signed [31:0] bias_lower;
    logic signed [31:0] bias_upper;
    logic signed [31:0] prior_low;
    logic signed [31:0] prior_high;
  } ibc_sum_t;

  // 64-bit add that sticks at the signed limits
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

endpackage

### src/interval_bound_concretizer_core.sv
// interval bound concretizer: one request (term) per cycle unless result_ready stalls it, one result per neuron
// a last term passes the request, product, sum and result registers before its result leaves
// throughput: 1 request per cycle while back-pressure from result_ready does not hold the pipeline
// reset: rst synchronous active high, clears valids and both accumulators to zero
// depends on ibc_pkg, ibc_mult, ibc_accum, ibc_final
module interval_bound_concretizer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  ibc_pkg::ibc_req_t request,
  output logic              result_valid,
  input  logic              result_ready,
  output ibc_pkg::ibc_rsp_t result
);

  // products of one term, floor-shifted to q48.16 in 64 bits
  logic               prod_valid;
  logic               prod_ready;
  ibc_pkg::ibc_prod_t prod;

  // finished sums, only on a last term
  logic              sum_valid;
  logic              sum_ready;
  ibc_pkg::ibc_sum_t sum;

  // request register, coefficient-sign operand select, multiply
  ibc_mult u_mult (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .prod_valid    (prod_valid),
    .prod_ready    (prod_ready),
    .prod          (prod)
  );

  // saturating accumulate; last term hands the sums on and clears
  ibc_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum        (sum)
  );

  // bias, clip, max/min with prior bounds, output register
  ibc_final u_final (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum_ready    (sum_ready),
    .sum          (sum),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### src/ibc_mult.sv
// request register and product register of the concretizer
// depends on ibc_pkg
module ibc_mult (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  ibc_pkg::ibc_req_t request,
  output logic              prod_valid,
  input  logic              prod_ready,
  output ibc_pkg::ibc_prod_t prod
);

  logic               req_v;
  ibc_pkg::ibc_req_t  req_r;
  logic               prod_v;
  ibc_pkg::ibc_prod_t prod_r;
  logic               prod_free;

  logic signed [31:0] low_operand;
  logic signed [31:0] high_operand;
  logic signed [63:0] raw_low;
  logic signed [63:0] raw_high;

  assign prod_free     = !prod_v || prod_ready;
  assign request_ready = !req_v || prod_free;

  // sign of each coefficient picks the source end
  assign low_operand  = req_r.lower_coef[31] ? req_r.source_high : req_r.source_low;
  assign high_operand = req_r.upper_coef[31] ? req_r.source_low : req_r.source_high;
  assign raw_low      = req_r.lower_coef * low_operand;
  assign raw_high     = req_r.upper_coef * high_operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_v  <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      if (request_ready) begin
        req_v <= request_valid;
      end
      if (prod_free) begin
        prod_v <= req_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request_ready && request_valid) begin
      req_r <= request;
    end
    if (prod_free && req_v) begin
      prod_r.prod_low   <= raw_low >>> ibc_pkg::FRAC_BITS;
      prod_r.prod_high  <= raw_high >>> ibc_pkg::FRAC_BITS;
      prod_r.bias_lower <= req_r.bias_lower;
      prod_r.bias_upper <= req_r.bias_upper;
      prod_r.prior_low  <= req_r.prior_low;
      prod_r.prior_high <= req_r.prior_high;
      prod_r.last_term  <= req_r.last_term;
    end
  end

  assign prod_valid = prod_v;
  assign prod       = prod_r;

endmodule

### src/ibc_accum.sv
// saturating accumulators and the register of finished sums
// depends on ibc_pkg
module ibc_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               prod_valid,
  output logic               prod_ready,
  input  ibc_pkg::ibc_prod_t prod,
  output logic               sum_valid,
  input  logic               sum_ready,
  output ibc_pkg::ibc_sum_t  sum
);

  logic signed [63:0] acc_low;
  logic signed [63:0] acc_high;
  logic signed [63:0] acc_low_next;
  logic signed [63:0] acc_high_next;
  logic               sum_v;
  ibc_pkg::ibc_sum_t  sum_r;
  logic               take;

  assign prod_ready    = !sum_v || sum_ready;
  assign take          = prod_valid && prod_ready;
  assign acc_low_next  = ibc_pkg::sat_add64(acc_low, prod.prod_low);
  assign acc_high_next = ibc_pkg::sat_add64(acc_high, prod.prod_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_low  <= '0;
      acc_high <= '0;
      sum_v    <= 1'b0;
    end else begin
      if (prod_ready) begin
        sum_v <= prod_valid && prod.last_term;
      end
      if (take) begin
        // last term hands the sums on and clears for the next neuron
        acc_low  <= prod.last_term ? '0 : acc_low_next;
        acc_high <= prod.last_term ? '0 : acc_high_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && prod.last_term) begin
      sum_r.sum_low    <= acc_low_next;
      sum_r.sum_high   <= acc_high_next;
      sum_r.bias_lower <= prod.bias_lower;
      sum_r.bias_upper <= prod.bias_upper;
      sum_r.prior_low  <= prod.prior_low;
      sum_r.prior_high <= prod.prior_high;
    end
  end

  assign sum_valid = sum_v;
  assign sum       = sum_r;

endmodule

### src/ibc_final.sv
// bias add, clip to 32 bits, tightening against prior bounds, result register
// depends on ibc_pkg
module ibc_final (
  input  logic              clk,
  input  logic              rst,
  input  logic              sum_valid,
  output logic              sum_ready,
  input  ibc_pkg::ibc_sum_t sum,
  output logic              result_valid,
  input  logic              result_ready,
  output ibc_pkg::ibc_rsp_t result
);

  logic signed [63:0] biased_low;
  logic signed [63:0] biased_high;
  logic signed [31:0] clip_low;
  logic signed [31:0] clip_high;
  logic               sat_low;
  logic               sat_high;
  logic               rsp_v;
  ibc_pkg::ibc_rsp_t  rsp_r;

  assign sum_ready   = !rsp_v || result_ready;
  assign biased_low  = ibc_pkg::sat_add64(sum.sum_low, 64'(sum.bias_lower));
  assign biased_high = ibc_pkg::sat_add64(sum.sum_high, 64'(sum.bias_upper));

  always_comb begin
    sat_low  = 1'b0;
    sat_high = 1'b0;
    clip_low  = biased_low[31:0];
    clip_high = biased_high[31:0];
    if (biased_low > ibc_pkg::BOUND_MAX) begin
      clip_low = ibc_pkg::BOUND_MAX[31:0];
      sat_low  = 1'b1;
    end else if (biased_low < ibc_pkg::BOUND_MIN) begin
      clip_low = ibc_pkg::BOUND_MIN[31:0];
      sat_low  = 1'b1;
    end
    if (biased_high > ibc_pkg::BOUND_MAX) begin
      clip_high = ibc_pkg::BOUND_MAX[31:0];
      sat_high  = 1'b1;
    end else if (biased_high < ibc_pkg::BOUND_MIN) begin
      clip_high = ibc_pkg::BOUND_MIN[31:0];
      sat_high  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_v <= 1'b0;
    end else if (sum_ready) begin
      rsp_v <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && sum_valid) begin
      rsp_r.new_low   <= (sum.prior_low > clip_low) ? sum.prior_low : clip_low;
      rsp_r.new_high  <= (sum.prior_high < clip_high) ? sum.prior_high : clip_high;
      rsp_r.saturated <= sat_low || sat_high;
    end
  end

  assign result_valid = rsp_v;
  assign result       = rsp_r;

endmodule

### tb/interval_bound_concretizer_core_tb.sv
// self-checking testbench for interval_bound_concretizer_core: streams terms, predicts
// each neuron's tightened bounds in a local model and compares every result field
// depends on ibc_pkg and interval_bound_concretizer_core
`timescale 1ns / 1ps

module interval_bound_concretizer_core_tb;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 11;
  localparam int TAIL_CYCLES = 12;         // extra wait after the last expected result is taken
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_TERMS = 400;
  localparam int HOLD_CYCLES = 300;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  logic              clk;
  logic              rst;
  logic              request_valid;
  logic              request_ready;
  ibc_pkg::ibc_req_t request;
  logic              result_valid;
  logic              result_ready;
  ibc_pkg::ibc_rsp_t result;

  // local copy of the two bound accumulators
  longint low_sum = 0;
  longint high_sum = 0;

  // expected tightened bounds, oldest first
  ibc_pkg::ibc_rsp_t bound_q[$];

  int send_idle = 0;      // percent of cycles the sender skips
  int recv_idle = 0;      // percent of cycles the sink drops ready
  int hold_len = 0;       // one-shot long stall for the sink
  int terms_offered = 0;
  int terms_taken = 0;
  int bounds_seen = 0;
  int clipped_seen = 0;
  int bad_fields = 0;
  int cycle_count = 0;

  interval_bound_concretizer_core u_top (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // 64-bit add that sticks at the limits instead of wrapping
  function automatic longint add_sticky(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  // fold one accepted term into the accumulators; a last term closes the neuron
  function automatic void fold_term(ibc_pkg::ibc_req_t t);
    longint            lc, uc, slo, shi, lo, hi;
    bit                clipped;
    ibc_pkg::ibc_rsp_t r;
    lc  = longint'(t.lower_coef);
    uc  = longint'(t.upper_coef);
    slo = longint'(t.source_low);
    shi = longint'(t.source_high);
    // sign of the coefficient picks which end of the source interval is the worst case
    // exact Q32.32 product, floor-shifted to Q48.16
    low_sum  = add_sticky(low_sum, (lc * (lc >= 0 ? slo : shi)) >>> ibc_pkg::FRAC_BITS);
    high_sum = add_sticky(high_sum, (uc * (uc >= 0 ? shi : slo)) >>> ibc_pkg::FRAC_BITS);
    if (!t.last_term) return;
    clipped = 1'b0;
    lo = add_sticky(low_sum, longint'(t.bias_lower));
    hi = add_sticky(high_sum, longint'(t.bias_upper));
    // clip to 32 bits before tightening against the prior bounds
    if (lo > ibc_pkg::BOUND_MAX) begin
      lo = ibc_pkg::BOUND_MAX;
      clipped = 1'b1;
    end else if (lo < ibc_pkg::BOUND_MIN) begin
      lo = ibc_pkg::BOUND_MIN;
      clipped = 1'b1;
    end
    if (hi > ibc_pkg::BOUND_MAX) begin
      hi = ibc_pkg::BOUND_MAX;
      clipped = 1'b1;
    end else if (hi < ibc_pkg::BOUND_MIN) begin
      hi = ibc_pkg::BOUND_MIN;
      clipped = 1'b1;
    end
    // tighten only; a crossed pair goes out as is
    if (longint'(t.prior_low) > lo) lo = longint'(t.prior_low);
    if (longint'(t.prior_high) < hi) hi = longint'(t.prior_high);
    r.new_low   = lo[31:0];
    r.new_high  = hi[31:0];
    r.saturated = clipped;
    bound_q.push_back(r);
    low_sum  = 0;
    high_sum = 0;
  endfunction

  // monitor: results are checked before the same edge's request is folded in
  always @(posedge clk) begin : check_bounds
    ibc_pkg::ibc_rsp_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        bounds_seen++;
        if (result.saturated) clipped_seen++;
        if (bound_q.size() == 0) begin
          $error("result with no pending neuron: new_low %0d new_high %0d",
                 result.new_low, result.new_high);
          bad_fields++;
        end else begin
          want = bound_q.pop_front();
          if (result.new_low !== want.new_low) begin
            $error("new_low: expected %0d, got %0d", want.new_low, result.new_low);
            bad_fields++;
          end
          if (result.new_high !== want.new_high) begin
            $error("new_high: expected %0d, got %0d", want.new_high, result.new_high);
            bad_fields++;
          end
          if (result.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, result.saturated);
            bad_fields++;
          end
        end
      end
      if (request_valid && request_ready) begin
        terms_taken++;
        fold_term(request);
      end
    end
  end

  // result sink: random ready, plus one long stall counted here when asked for
  initial begin : result_sink
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        result_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      result_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d neurons still pending", cycle_count,
               bound_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic ibc_pkg::ibc_req_t make_term(logic signed [31:0] lc,
                                                  logic signed [31:0] uc,
                                                  logic signed [31:0] slo,
                                                  logic signed [31:0] shi,
                                                  logic signed [31:0] bl,
                                                  logic signed [31:0] bu,
                                                  logic signed [31:0] pl,
                                                  logic signed [31:0] ph,
                                                  logic last);
    ibc_pkg::ibc_req_t t;
    t.lower_coef  = lc;
    t.upper_coef  = uc;
    t.source_low  = slo;
    t.source_high = shi;
    t.bias_lower  = bl;
    t.bias_upper  = bu;
    t.prior_low   = pl;
    t.prior_high  = ph;
    t.last_term   = last;
    return t;
  endfunction

  // mostly small Q16.16 values within +-8.0, with extremes and full-width noise
  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(9))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2, 3:    return $urandom();
      default: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
    endcase
  endfunction

  // send one request; called and returning at a rising edge, valid left high
  task automatic send_term(ibc_pkg::ibc_req_t t);
    if ($urandom_range(99) < send_idle) begin
      request_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    request_valid <= 1'b1;
    request       <= t;
    terms_offered++;
    do @(posedge clk); while (!request_ready);
  endtask

  // stop offering and wait for every pending neuron plus the pipeline tail
  task automatic drain_bounds();
    request_valid <= 1'b0;
    while (bound_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // single-term neurons at the corners of the fields
  task automatic test_edge_values();
    send_idle = 20;
    recv_idle = 30;
    send_term(make_term(0, 0, 0, 0, 0, 0, Q_MIN, Q_MAX, 1'b1));
    // negative lower coef takes source_high, positive upper takes source_high: both clip
    send_term(make_term(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 0, Q_MIN, Q_MAX, 1'b1));
    // min times min is the largest product magnitude
    send_term(make_term(Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 1'b1));
    send_term(make_term(Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 1'b1));
    // floor rounding of a tiny negative product
    send_term(make_term(-1, -1, 1, 1, 0, 0, Q_MIN, Q_MAX, 1'b1));
    send_term(make_term(1, 1, -1, 1, -1, 1, Q_MIN, Q_MAX, 1'b1));
    // bias alone pushes an in-range sum past 32 bits
    send_term(make_term(32'sh7FFF_0000, 32'sh8001_0000, Q_ONE, Q_ONE, Q_MAX, Q_MIN,
                        Q_MIN, Q_MAX, 1'b1));
    drain_bounds();
  endtask

  // several terms per neuron with bias and prior tightening
  task automatic test_multi_term();
    // bias and prior on non-last terms must be ignored
    send_term(make_term(2 * Q_ONE, -(Q_ONE + Q_ONE / 2), -Q_ONE, 3 * Q_ONE,
                        Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0));
    send_term(make_term(-(Q_ONE / 2), Q_ONE / 4, 2 * Q_ONE, 4 * Q_ONE,
                        Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0));
    // prior_high is tighter than the computed upper bound
    send_term(make_term(Q_ONE, Q_ONE, -2 * Q_ONE, Q_ONE, Q_ONE / 2, -(Q_ONE / 2),
                        -100 * Q_ONE, Q_ONE, 1'b1));
    // prior_low is tighter than the computed lower bound
    send_term(make_term(Q_ONE, -Q_ONE, -5 * Q_ONE, 5 * Q_ONE, 0, 0, 0, Q_MAX, 1'b0));
    send_term(make_term(3 * Q_ONE, 2 * Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE,
                        2 * Q_ONE, 100 * Q_ONE, 1'b1));
    // residual-layer terms: plain terms with zero bias
    send_term(make_term(Q_ONE / 3, Q_ONE / 3, -7 * Q_ONE, 6 * Q_ONE, 0, 0, 0, 0, 1'b0));
    send_term(make_term(-Q_ONE / 7, Q_ONE / 5, Q_ONE, 9 * Q_ONE, 0, 0, Q_MIN, Q_MAX, 1'b1));
    drain_bounds();
  endtask

  // swapped source interval and crossed result pass through unchecked
  task automatic test_odd_intervals();
    send_term(make_term(Q_ONE, Q_ONE, 5 * Q_ONE, -5 * Q_ONE, 0, 0, Q_MIN, Q_MAX, 1'b1));
    send_term(make_term(-Q_ONE, -Q_ONE, 5 * Q_ONE, -5 * Q_ONE, 0, 0, Q_MIN, Q_MAX, 1'b1));
    send_term(make_term(Q_ONE, Q_ONE, -Q_ONE, Q_ONE, 0, 0, 10 * Q_ONE, -10 * Q_ONE, 1'b1));
    // sum leaves 32 bits mid-neuron and is pulled back by the last term
    send_term(make_term(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0, 1'b0));
    send_term(make_term(Q_MIN, Q_MIN, Q_MAX, Q_MAX, 0, 0, Q_MIN, Q_MAX, 1'b1));
    drain_bounds();
  endtask

  // neuron of random length and content
  task automatic send_random_neuron();
    int                n;
    ibc_pkg::ibc_req_t t;
    n = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      t.lower_coef  = rand_q();
      t.upper_coef  = rand_q();
      t.source_low  = rand_q();
      t.source_high = rand_q();
      t.bias_lower  = rand_q();
      t.bias_upper  = rand_q();
      t.prior_low   = rand_q();
      t.prior_high  = rand_q();
      t.last_term   = (i == n - 1);
      // an open prior lets the computed bound through
      if (t.last_term && $urandom_range(2) == 0) begin
        t.prior_low  = Q_MIN;
        t.prior_high = Q_MAX;
      end
      send_term(t);
    end
  endtask

  // sink stalls long while the sender keeps offering, so the input backs up
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 10;
    hold_len  = HOLD_CYCLES;
    for (int i = 0; i < 60; i++) begin
      send_term(make_term(rand_q(), rand_q(), rand_q(), rand_q(), 0, 0, 0, 0, 1'b0));
      send_term(make_term(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                          rand_q(), rand_q(), 1'b1));
    end
    drain_bounds();
  endtask

  task automatic test_random(int sender_pct, int sink_pct, int count);
    int first;
    send_idle = sender_pct;
    recv_idle = sink_pct;
    first = terms_offered;
    while (terms_offered - first < count) send_random_neuron();
    drain_bounds();
  endtask

  initial begin
    rst           = 1'b1;
    request_valid = 1'b0;
    request       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_edge_values();
    test_multi_term();
    test_odd_intervals();
    test_backpressure();
    test_random(31, 88, PHASE_TERMS);
    test_random(88, 31, PHASE_TERMS);
    test_random(0, 0, PHASE_TERMS);

    $display("streamed %0d terms into %0d neuron bounds (%0d clipped), %0d field errors",
             terms_taken, bounds_seen, clipped_seen, bad_fields);
    $display("covered corner values, multi-term neurons, odd intervals, long sink stall");
    if (bad_fields == 0 && bound_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
